// ===== rtl/first_order_lowpass_filter_macros.svh =====
// Assertion macros used by the port-level checker of the low-pass filter.
`ifndef FIRST_ORDER_LOWPASS_FILTER_MACROS_SVH
`define FIRST_ORDER_LOWPASS_FILTER_MACROS_SVH

// Checked at every clock edge, muted while reset is held.
`define FLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define FLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/flp_pkg.sv =====
// Package of the first-order low-pass filter: widths, codes, types.
`timescale 1ns / 1ps
package flp_pkg;

  // Fraction bits of the gain; the gain itself needs one more bit.
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_W         = GAIN_FRAC_BITS + 1;
  localparam int CNT_W          = $clog2(GAIN_W + 1);

  // Field widths
  localparam int DATA_W = 32;
  localparam int DT_W   = 20;
  localparam int TAU_W  = 24;
  localparam int CMD_W  = 2;

  // Divider and multiplier datapath widths
  localparam int DEN_W  = TAU_W + 1;
  localparam int REM_W  = DEN_W + 1;
  localparam int ACC_W  = DATA_W + 2;

  // Commands
  localparam logic [CMD_W-1:0] CMD_APPLY    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPLY_DT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PRELOAD  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_INIT     = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_MUL,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DT_W-1:0]  dt;
    logic [TAU_W-1:0] tau;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== rtl/flp_div.sv =====
// Bit-serial restoring divider computing the gain dt * 2^F / (tau + dt).
`timescale 1ns / 1ps
module flp_div
  import flp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r, den_nxt;
  logic [GAIN_W-1:0] quot_r, quot_nxt;

  logic              ge;
  logic [REM_W-1:0]  rem_sub;
  logic [REM_W-1:0]  rem_sel;

  // One quotient bit per cycle, most significant first
  always_comb begin
    ge       = rem_r >= {1'b0, den_r};
    rem_sub  = rem_r - {1'b0, den_r};
    rem_sel  = ge ? rem_sub : rem_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    if (req.start) begin
      rem_nxt  = REM_W'(req.dt);
      den_nxt  = DEN_W'(req.tau) + DEN_W'(req.dt);
      quot_nxt = '0;
      cnt_nxt  = CNT_W'(GAIN_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = {quot_r[GAIN_W-2:0], ge};
      // remainder stays below the divisor, so the top bit drops safely
      rem_nxt  = {rem_sel[REM_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  // Zero time step with zero tau gives zero gain
  assign rsp.done = done_r;
  assign rsp.quot = (den_r == '0) ? '0 : quot_r;

endmodule

// ===== rtl/first_order_lowpass_filter.sv =====
// Top level of the first-order low-pass filter with serial gain and update.
//
// Usage:
//   Input channel in_valid/in_ready carries one item: in_cmd, in_sample_value
//   (signed Q16.16) and in_time_step (microseconds). Result channel
//   out_valid/out_ready returns out_filtered_value, the filter state after
//   the item; every item gives exactly one result.
//   cfg_wr_en/cfg_wr_data write rc_tau; it takes effect at the next gain
//   computation (commands apply-with-dt and init).
// Processing (F = 16 gain fraction bits):
//   preload loads the state directly; apply forms x - state, runs a serial
//   shift-add multiply, one gain bit per cycle, and adds product >> F; init
//   clears the state and runs a serial restoring division, one quotient bit
//   per cycle; apply with new dt runs the division and then the apply steps.
//   One item is in work at a time; in_ready is high only while idle, so the
//   next item is accepted in the cycle after the result is loaded. The next
//   item is taken while a result still sits in the output register.
// Reset clears filter state, gain and rc_tau and empties the output register.
// When the receiver stalls, a finished item waits until the output register
// is free; the held result stays stable until taken.
`timescale 1ns / 1ps
module first_order_lowpass_filter
  import flp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [DATA_W-1:0] in_sample_value,
  input  logic [DT_W-1:0]          in_time_step,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_filtered_value,
  input  logic                     cfg_wr_en,
  input  logic [TAU_W-1:0]         cfg_wr_data
);

  state_t            state_r, state_nxt;
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [DATA_W-1:0] sample_r, sample_nxt;
  logic [DATA_W-1:0] filt_r, filt_nxt;
  logic [TAU_W-1:0]  tau_r, tau_nxt;
  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic [ACC_W-1:0]  diff_r, diff_nxt;
  logic [ACC_W-1:0]  hi_r, hi_nxt;
  logic [GAIN_W-1:0] lo_r, lo_nxt;
  logic [GAIN_W-1:0] gsh_r, gsh_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;

  logic [ACC_W-1:0]  sum;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  flp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == ST_IDLE);

  // Next state and datapath control
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    sample_nxt    = sample_r;
    filt_nxt      = filt_r;
    gain_nxt      = gain_r;
    diff_nxt      = diff_r;
    hi_nxt        = hi_r;
    lo_nxt        = lo_r;
    gsh_nxt       = gsh_r;
    cnt_nxt       = cnt_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    tau_nxt       = cfg_wr_en ? cfg_wr_data : tau_r;
    div_req.start = 1'b0;
    div_req.dt    = in_time_step;
    div_req.tau   = tau_r;
    sum           = hi_r + (gsh_r[0] ? diff_r : '0);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = in_cmd;
          sample_nxt = in_sample_value;
          unique case (in_cmd)
            CMD_APPLY: state_nxt = ST_PREP;
            CMD_APPLY_DT: begin
              div_req.start = 1'b1;
              state_nxt     = ST_DIV;
            end
            CMD_PRELOAD: begin
              filt_nxt  = in_sample_value;
              state_nxt = ST_DONE;
            end
            default: begin
              filt_nxt      = '0;
              div_req.start = 1'b1;
              state_nxt     = ST_DIV;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          gain_nxt  = div_rsp.quot;
          state_nxt = (cmd_r == CMD_INIT) ? ST_DONE : ST_PREP;
        end
      end
      ST_PREP: begin
        // difference x - state, sign-extended with a guard bit for the adds
        diff_nxt  = {{2{sample_r[DATA_W-1]}}, sample_r} - {{2{filt_r[DATA_W-1]}}, filt_r};
        hi_nxt    = '0;
        gsh_nxt   = gain_r;
        cnt_nxt   = CNT_W'(GAIN_W);
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        // shift-add over gain bits, LSB first, arithmetic right shift
        hi_nxt  = {sum[ACC_W-1], sum[ACC_W-1:1]};
        lo_nxt  = {sum[0], lo_r[GAIN_W-1:1]};
        gsh_nxt = gsh_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        // product >> F; the new state stays between old state and sample
        filt_nxt  = filt_r + {hi_r[DATA_W-2:0], lo_r[GAIN_W-1]};
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = filt_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      filt_r      <= '0;
      gain_r      <= '0;
      tau_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      filt_r      <= filt_nxt;
      gain_r      <= gain_nxt;
      tau_r       <= tau_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    sample_r   <= sample_nxt;
    diff_r     <= diff_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    gsh_r      <= gsh_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_data_r;

endmodule

// ===== rtl/flp_chk.sv =====
// Port-level checker for the low-pass filter, bound to the top level.
`timescale 1ns / 1ps
`include "first_order_lowpass_filter_macros.svh"
module flp_chk
  import flp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DATA_W-1:0] out_filtered_value
);

  // A stalled result stays offered
  `FLP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")

  // A stalled result keeps its value
  `FLP_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_filtered_value), "stalled result changed")

  // One item at a time: an accept closes the input until the item is done
  `FLP_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "input accepted twice in a row")

  // Reset empties the output register
  `FLP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result offered after reset")

endmodule

bind first_order_lowpass_filter flp_chk u_flp_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_filtered_value (out_filtered_value)
);

// ===== sim/first_order_lowpass_filter_checker.sv =====
// Checker of the low-pass filter: predicts the state after each item and compares results.
`timescale 1ns / 1ps
module first_order_lowpass_filter_checker
  import flp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic signed [DATA_W-1:0] in_sample_value,
  input  logic [DT_W-1:0]          in_time_step,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic signed [DATA_W-1:0] out_filtered_value,
  input  logic                     cfg_wr_en,
  input  logic [TAU_W-1:0]         cfg_wr_data,
  output int                       mismatch_count,
  output int                       pending_count
);

  // Mirror of the filter state and of the rc_tau register
  logic signed [DATA_W-1:0] model_state;
  logic [DT_W-1:0]          model_step;
  logic [GAIN_W-1:0]        model_gain;
  logic [TAU_W-1:0]         model_tau;

  // Filter states still to come out of the block, oldest first
  logic signed [DATA_W-1:0] expected_states[$];
  int                       errors;

  // alpha = floor(dt * 2^F / (tau + dt)); zero when both are zero
  function automatic logic [GAIN_W-1:0] gain_for(input logic [DT_W-1:0]  dt,
                                                 input logic [TAU_W-1:0] tau);
    logic [DEN_W-1:0]               den;
    logic [DT_W+GAIN_FRAC_BITS-1:0] num;
    logic [DT_W+GAIN_FRAC_BITS-1:0] quot;
    den = DEN_W'(tau) + DEN_W'(dt);
    num = (DT_W+GAIN_FRAC_BITS)'(dt) << GAIN_FRAC_BITS;
    if (den == '0) begin
      return '0;
    end
    quot = num / den;
    return quot[GAIN_W-1:0];
  endfunction

  // state + floor(alpha * (x - state) / 2^F), clamped to the sample range
  function automatic logic signed [DATA_W-1:0] smoothed(
      input logic signed [DATA_W-1:0] st,
      input logic signed [DATA_W-1:0] x,
      input logic [GAIN_W-1:0]        g);
    longint diff;
    longint prod;
    longint nxt;
    diff = longint'(x) - longint'(st);
    prod = longint'(g) * diff;
    nxt  = longint'(st) + (prod >>> GAIN_FRAC_BITS);
    if (nxt > 64'sd2147483647) begin
      nxt = 64'sd2147483647;
    end
    if (nxt < -64'sd2147483648) begin
      nxt = -64'sd2147483648;
    end
    return nxt[DATA_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [DATA_W-1:0] want;
    if (!rst_n) begin
      model_state = '0;
      model_step  = '0;
      model_gain  = '0;
      model_tau   = '0;
      expected_states.delete();
      errors      = 0;
    end else begin
      // results first: a result leaving at the edge that takes the next item is the older one
      if (out_valid && out_ready) begin
        if (expected_states.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected result: got %0d (0x%08h)", out_filtered_value,
                     out_filtered_value);
          end
        end else begin
          want = expected_states.pop_front();
          if (out_filtered_value !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("filtered_value mismatch: expected %0d (0x%08h) got %0d (0x%08h)",
                       want, want, out_filtered_value, out_filtered_value);
            end
          end
        end
      end

      if (cfg_wr_en) begin
        model_tau = cfg_wr_data;
      end

      // predict the state after each accepted item
      if (in_valid && in_ready) begin
        case (in_cmd)
          CMD_APPLY: begin
            model_state = smoothed(model_state, in_sample_value, model_gain);
          end
          CMD_APPLY_DT: begin
            model_step  = in_time_step;
            model_gain  = gain_for(model_step, model_tau);
            model_state = smoothed(model_state, in_sample_value, model_gain);
          end
          CMD_PRELOAD: begin
            model_state = in_sample_value;
          end
          default: begin
            model_state = '0;
            model_step  = in_time_step;
            model_gain  = gain_for(model_step, model_tau);
          end
        endcase
        expected_states.push_back(model_state);
      end
    end
    mismatch_count <= errors;
    pending_count  <= expected_states.size();
  end

endmodule

// ===== sim/testbench.sv =====
// Top of the low-pass filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import flp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 80;

  logic                     clk;
  logic                     rst_n              = 1'b0;
  logic                     in_valid           = 1'b0;
  logic                     in_ready;
  logic [CMD_W-1:0]         in_cmd             = CMD_APPLY;
  logic signed [DATA_W-1:0] in_sample_value    = '0;
  logic [DT_W-1:0]          in_time_step       = '0;
  logic                     out_valid;
  logic                     out_ready          = 1'b0;
  logic signed [DATA_W-1:0] out_filtered_value;
  logic                     cfg_wr_en          = 1'b0;
  logic [TAU_W-1:0]         cfg_wr_data        = '0;

  int mismatch_count;
  int pending_count;
  int cycle_count = 0;
  bit steady      = 1'b0;

  first_order_lowpass_filter i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_sample_value   (in_sample_value),
    .in_time_step      (in_time_step),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_filtered_value(out_filtered_value),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  first_order_lowpass_filter_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_sample_value   (in_sample_value),
    .in_time_step      (in_time_step),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_filtered_value(out_filtered_value),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // receiver: random stall before each result, none while steady
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // offer one item after a random gap (none while steady), return once it is taken
  task automatic send_item(input logic [CMD_W-1:0] cmd,
                           input logic signed [DATA_W-1:0] x,
                           input logic [DT_W-1:0] dt);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_sample_value <= x;
    in_time_step    <= dt;
    do @(posedge clk); while (!in_ready);
  endtask

  // wait until every item has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // rc_tau is only written with the block idle
  task automatic write_tau(input logic [TAU_W-1:0] tau);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tau;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly applies, with preloads and re-inits mixed in
  task automatic random_item();
    int                       pick;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] x;
    logic [DT_W-1:0]          dt;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      cmd = CMD_APPLY;
    end else if (pick < 75) begin
      cmd = CMD_APPLY_DT;
    end else if (pick < 88) begin
      cmd = CMD_PRELOAD;
    end else begin
      cmd = CMD_INIT;
    end
    case ($urandom_range(0, 7))
      0:       x = 32'sh7FFFFFFF;
      1:       x = 32'sh80000000;
      2:       x = $signed($urandom_range(0, 131071)) - 65536;
      default: x = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0:       dt = '0;
      1:       dt = '1;
      2, 3:    dt = DT_W'($urandom_range(1, 2000));
      default: dt = DT_W'($urandom_range(0, (1 << DT_W) - 1));
    endcase
    send_item(cmd, x, dt);
  endtask

  initial begin
    logic [TAU_W-1:0] tau;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // gain is zero after reset: applies hold the state
    send_item(CMD_APPLY, 32'sh7FFFFFFF, '0);
    send_item(CMD_PRELOAD, 32'sh80000000, '0);
    send_item(CMD_APPLY, 32'sh7FFFFFFF, '0);
    // zero step with zero tau gives zero gain
    send_item(CMD_INIT, 32'sh12345678, '0);
    send_item(CMD_APPLY_DT, 32'sh7FFFFFFF, '0);
    // zero tau: full gain, state follows the sample across the whole range
    send_item(CMD_APPLY_DT, 32'sh80000000, 20'd1);
    send_item(CMD_APPLY, 32'sh7FFFFFFF, '0);
    send_item(CMD_PRELOAD, '0, '1);

    // largest tau and largest step
    write_tau('1);
    send_item(CMD_INIT, 32'sh7FFFFFFF, '1);
    send_item(CMD_APPLY, 32'sh7FFFFFFF, '0);
    send_item(CMD_APPLY, 32'sh80000000, '0);
    send_item(CMD_APPLY_DT, 32'sh7FFFFFFF, 20'd1);

    // tau equal to the step: half gain
    write_tau(24'd1000);
    send_item(CMD_INIT, '0, 20'd1000);
    send_item(CMD_APPLY, 32'sh12345678, '0);
    send_item(CMD_APPLY, -32'sd1, '0);
    send_item(CMD_APPLY_DT, 32'sh80000000, 20'd3000);
    send_item(CMD_PRELOAD, 32'sh7FFFFFFF, '0);
    send_item(CMD_APPLY, 32'sh80000000, '0);
    // zero step with nonzero tau also gives zero gain
    send_item(CMD_INIT, '0, '0);
    send_item(CMD_APPLY, 32'sh7FFFFFFF, '0);

    // random phases, each with its own tau
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       tau = '0;
        1:       tau = '1;
        2:       tau = 24'd1;
        3, 4:    tau = TAU_W'($urandom_range(1, 5000));
        default: tau = TAU_W'($urandom_range(0, (1 << TAU_W) - 1));
      endcase
      write_tau(tau);
      steady = (phase % 3 == 2);
      send_item(CMD_INIT, '0, DT_W'($urandom_range(1, 4000)));
      repeat (PHASE_ITEMS) random_item();
    end
    steady = 1'b0;

    drain();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
